/* rtl/bgp_pkg.sv */
// Shared types and constants of the genotype base-3 packer.
// Used by the accumulator store, the result queue and the top level; no dependencies.
package bgp_pkg;

  // lanes per genotype byte and code width
  localparam int unsigned LANES      = 4;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned VAL_W      = 2;

  // accumulator and running sum widths
  localparam int unsigned ACC_W      = 13;
  localparam int unsigned SUM_W      = 14;
  localparam int unsigned SQ_W       = 15;
  localparam int unsigned PHENO_MAX  = 2;

  // configuration port
  localparam int unsigned NUM_IND_W  = 13;
  localparam int unsigned SEG_LEN_W  = 4;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  // stream words
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned RES_BITS    = LANES * ACC_W + LANES + 2 * SUM_W + 2 * SQ_W;
  localparam int unsigned OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - RES_BITS;

  // result queue
  localparam int unsigned OQ_DEPTH   = 3;
  localparam int unsigned OQ_PTR_W   = 2;
  localparam int unsigned OQ_CNT_W   = 2;

  // reset values of the registers
  localparam logic [NUM_IND_W-1:0] NUM_IND_RESET = NUM_IND_W'(4096);
  localparam logic [SEG_LEN_W-1:0] SEG_LEN_RESET = SEG_LEN_W'(5);

  // genotype codes
  localparam logic [CODE_W-1:0] CODE_MISSING = 2'd1;

  // saturation limits
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_INDIVIDUALS = 1'b0,
    REG_SEGMENT_LEN     = 1'b1
  } cfg_idx_e;

  typedef logic [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [SQ_W-1:0]        square_sum_second;
    logic [SQ_W-1:0]        square_sum_first;
    logic [SUM_W-1:0]       sum_second;
    logic [SUM_W-1:0]       sum_first;
    logic                   row_end;
    logic [LANES-1:0]       missing_flags;
    acc_t [LANES-1:0]       packed_slot;
  } result_t;

endpackage

/* rtl/bgp_acc_store.sv */
// Accumulator store: one synchronous memory per lane, one word per row byte.
// Forwards a write that lands on the entry read in the same cycle. Uses bgp_pkg.
module bgp_acc_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                                        clk_i,
  input  logic                                        rd_en_i,
  input  logic [AW-1:0]                               rd_addr_i,
  output bgp_pkg::acc_t [bgp_pkg::LANES-1:0]          rd_data_o,
  input  logic [bgp_pkg::LANES-1:0]                   wr_en_i,
  input  logic [AW-1:0]                               wr_addr_i,
  input  bgp_pkg::acc_t [bgp_pkg::LANES-1:0]          wr_data_i
);
  import bgp_pkg::*;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    acc_t mem_q [DEPTH];
    acc_t rdata_q;
    acc_t fwd_data_q;
    logic fwd_q;

    // lane memory, read-before-write
    always_ff @(posedge clk_i) begin
      if (wr_en_i[l]) begin
        mem_q[wr_addr_i] <= wr_data_i[l];
      end
      if (rd_en_i) begin
        rdata_q <= mem_q[rd_addr_i];
      end
    end

    // bypass of a write to the entry being read
    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        fwd_q      <= wr_en_i[l] && (wr_addr_i == rd_addr_i);
        fwd_data_q <= wr_data_i[l];
      end
    end

    assign rd_data_o[l] = fwd_q ? fwd_data_q : rdata_q;
  end

endmodule

/* rtl/bgp_out_queue.sv */
// Small result queue between the update stage and the output stream.
// Holds up to OQ_DEPTH result words. Uses bgp_pkg.
module bgp_out_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  bgp_pkg::result_t                  push_data_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output bgp_pkg::result_t                  data_o,
  output logic [bgp_pkg::OQ_CNT_W-1:0]      count_o
);
  import bgp_pkg::*;

  result_t              entry_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [OQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [OQ_CNT_W-1:0]  count_q, count_d;
  logic                 pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/bed_genotype_base3_packer.sv */
// Top level of the genotype byte decoder and base-3 packer.
// Depends on bgp_pkg, bgp_acc_store and bgp_out_queue.
//
// Usage:
//   s_axis carries one word per genotype byte: four 2-bit codes and eight
//   phenotype mask bits. Bytes of a SNP row follow each other, rows follow rows.
//   m_axis returns one word per input word: the four updated base-3
//   accumulators, the missing flags and, on the row's last byte (tlast), the
//   masked sums and sums of squares of both phenotypes.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i set num_individuals and segment_len; write
//   them only while no word is in flight.
// Timing:
//   one word per cycle sustained while m_axis keeps up. The accumulator memory is
//   read on the accept edge and written back in the next cycle; a bypass covers
//   rows of one byte. A result passes the update stage and the result queue to m_axis.
// Reset and stall:
//   reset clears row and segment position, sums and the result queue; the
//   accumulator memory is not cleared, every entry is written at the first
//   SNP of a segment before it is read. When m_axis stalls, results collect in
//   a three-word queue and s_axis_tready drops once the queue would be full.
module bed_genotype_base3_packer #(
  parameter int unsigned MAX_INDIVIDUALS = 4096,
  parameter int unsigned MAX_SEGMENT_LEN = 8,
  parameter int unsigned PHENO_COUNT     = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [bgp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bgp_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // geno_byte[7:0], pheno_bits[15:8]
  input  logic [bgp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // packed_slot0[12:0], packed_slot1[25:13], packed_slot2[38:26],
  // packed_slot3[51:39], missing_flags[55:52], sum_first[69:56],
  // sum_second[83:70], square_sum_first[98:84], square_sum_second[113:99], zeros
  output logic [bgp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // row_end
  output logic                                 m_axis_tlast
);
  import bgp_pkg::*;

  localparam int unsigned IND_CLOG = $clog2(MAX_INDIVIDUALS + 1);
  localparam int unsigned NW       = (IND_CLOG > NUM_IND_W) ? IND_CLOG : NUM_IND_W;
  localparam int unsigned DEPTH    = (MAX_INDIVIDUALS + LANES - 1) / LANES;
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW       = (MAX_SEGMENT_LEN > 1) ? $clog2(MAX_SEGMENT_LEN) : 1;

  // configuration registers
  logic [NUM_IND_W-1:0] num_ind_q, num_ind_d;
  logic [SEG_LEN_W-1:0] seg_len_q, seg_len_d;

  always_comb begin
    num_ind_d = num_ind_q;
    seg_len_d = seg_len_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_NUM_INDIVIDUALS: num_ind_d = cfg_wdata_i;
        REG_SEGMENT_LEN:     seg_len_d = cfg_wdata_i[SEG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ind_q <= NUM_IND_RESET;
      seg_len_q <= SEG_LEN_RESET;
    end else begin
      num_ind_q <= num_ind_d;
      seg_len_q <= seg_len_d;
    end
  end

  // row and segment position, evaluated at accept
  logic [AW-1:0]    byte_pos_q, byte_pos_d;
  logic [SW-1:0]    snp_q, snp_d;
  logic [NW-1:0]    n_ext, n_eff;
  logic [NW:0]      n_plus, bp_ext, base;
  logic             row_last;
  logic [LANES-1:0] lane_vld;
  logic [SEG_LEN_W-1:0] seg_eff, snp_inc;
  logic [SW-1:0]    snp_cur;
  logic             restart;
  logic             in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    n_ext = NW'(num_ind_q);
    if (n_ext == '0) begin
      n_eff = NW'(1);
    end else if (n_ext > NW'(MAX_INDIVIDUALS)) begin
      n_eff = NW'(MAX_INDIVIDUALS);
    end else begin
      n_eff = n_ext;
    end
    n_plus   = {1'b0, n_eff} + (NW + 1)'(LANES - 1);
    bp_ext   = (NW + 1)'(byte_pos_q);
    row_last = (bp_ext + 1'b1) >= (NW + 1)'(n_plus[NW:2]);
    base     = bp_ext << 2;
    for (int l = 0; l < LANES; l++) begin
      lane_vld[l] = (base + (NW + 1)'(l)) < {1'b0, n_eff};
    end

    if (seg_len_q == '0) begin
      seg_eff = SEG_LEN_W'(1);
    end else if (seg_len_q > SEG_LEN_W'(MAX_SEGMENT_LEN)) begin
      seg_eff = SEG_LEN_W'(MAX_SEGMENT_LEN);
    end else begin
      seg_eff = seg_len_q;
    end
    snp_cur = (SEG_LEN_W'(snp_q) >= seg_eff) ? '0 : snp_q;
    restart = (snp_cur == '0);
    snp_inc = SEG_LEN_W'(snp_cur) + 1'b1;

    byte_pos_d = byte_pos_q;
    snp_d      = snp_q;
    if (in_acc) begin
      if (row_last) begin
        byte_pos_d = '0;
        snp_d      = (snp_inc >= seg_eff) ? '0 : SW'(snp_inc);
      end else begin
        byte_pos_d = byte_pos_q + 1'b1;
        snp_d      = snp_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= '0;
      snp_q      <= '0;
    end else begin
      byte_pos_q <= byte_pos_d;
      snp_q      <= snp_d;
    end
  end

  // update stage registers
  logic             s1_valid_q;
  logic [7:0]       s1_geno_q;
  logic [7:0]       s1_mask_q;
  logic [AW-1:0]    s1_addr_q;
  logic [LANES-1:0] s1_lane_q;
  logic             s1_restart_q;
  logic             s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_geno_q    <= s_axis_tdata[7:0];
      s1_mask_q    <= s_axis_tdata[15:8];
      s1_addr_q    <= byte_pos_q;
      s1_lane_q    <= lane_vld;
      s1_restart_q <= restart;
      s1_last_q    <= row_last;
    end
  end

  // accumulator memory
  acc_t [LANES-1:0] old_acc;
  acc_t [LANES-1:0] new_acc;
  logic [LANES-1:0] acc_we;

  bgp_acc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (byte_pos_q),
    .rd_data_o (old_acc),
    .wr_en_i   (acc_we),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (new_acc)
  );

  // decode, fold and sum
  logic [SUM_W-1:0] run_sum_q [PHENO_MAX];
  logic [SQ_W-1:0]  run_sq_q  [PHENO_MAX];
  logic [SUM_W-1:0] sum_sat [PHENO_MAX];
  logic [SQ_W-1:0]  sq_sat  [PHENO_MAX];
  logic [3:0]       add_sum [PHENO_MAX];
  logic [4:0]       add_sq  [PHENO_MAX];
  logic [SUM_W:0]   sum_tot [PHENO_MAX];
  logic [SQ_W:0]    sq_tot  [PHENO_MAX];
  logic [CODE_W-1:0] code [LANES];
  logic [VAL_W-1:0]  val  [LANES];
  acc_t              base_acc [LANES];
  result_t           res;

  always_comb begin
    res = '0;
    for (int p = 0; p < PHENO_MAX; p++) begin
      add_sum[p] = '0;
      add_sq[p]  = '0;
    end
    for (int l = 0; l < LANES; l++) begin
      code[l]     = s1_geno_q[CODE_W*l +: CODE_W];
      val[l]      = code[l][1] ? code[l] - 1'b1 : '0;
      base_acc[l] = s1_restart_q ? '0 : old_acc[l];
      new_acc[l]  = ACC_W'({base_acc[l], 1'b0}) + base_acc[l] + ACC_W'(val[l]);
      acc_we[l]   = s1_valid_q && s1_lane_q[l];
      if (s1_lane_q[l]) begin
        res.packed_slot[l]   = new_acc[l];
        res.missing_flags[l] = (code[l] == CODE_MISSING);
        for (int p = 0; p < PHENO_MAX; p++) begin
          if ((p < PHENO_COUNT) && s1_mask_q[2*l + p]) begin
            add_sum[p] = add_sum[p] + 4'(val[l]);
            add_sq[p]  = add_sq[p] + (val[l][1] ? 5'd4 : 5'(val[l]));
          end
        end
      end
    end
    for (int p = 0; p < PHENO_MAX; p++) begin
      sum_tot[p] = {1'b0, run_sum_q[p]} + (SUM_W + 1)'(add_sum[p]);
      sq_tot[p]  = {1'b0, run_sq_q[p]} + (SQ_W + 1)'(add_sq[p]);
      sum_sat[p] = sum_tot[p][SUM_W] ? SUM_MAX : sum_tot[p][SUM_W-1:0];
      sq_sat[p]  = sq_tot[p][SQ_W] ? SQ_MAX : sq_tot[p][SQ_W-1:0];
    end
    res.row_end = s1_last_q;
    if (s1_last_q) begin
      res.sum_first         = sum_sat[0];
      res.sum_second        = sum_sat[1];
      res.square_sum_first  = sq_sat[0];
      res.square_sum_second = sq_sat[1];
    end
  end

  // running sums, cleared after the row's last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PHENO_MAX; p++) begin
        run_sum_q[p] <= '0;
        run_sq_q[p]  <= '0;
      end
    end else if (s1_valid_q) begin
      for (int p = 0; p < PHENO_MAX; p++) begin
        run_sum_q[p] <= s1_last_q ? '0 : sum_sat[p];
        run_sq_q[p]  <= s1_last_q ? '0 : sq_sat[p];
      end
    end
  end

  // result queue and output word
  result_t             out_res;
  logic [OQ_CNT_W-1:0] oq_count;

  bgp_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (res),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res),
    .count_o     (oq_count)
  );

  // room for the word in flight plus the new one
  assign s_axis_tready = ((OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(s1_valid_q))
                         < (OQ_CNT_W + 1)'(OQ_DEPTH);

  assign m_axis_tlast = out_res.row_end;
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}},
                         out_res.square_sum_second,
                         out_res.square_sum_first,
                         out_res.sum_second,
                         out_res.sum_first,
                         out_res.missing_flags,
                         out_res.packed_slot};

endmodule
